>>> sv/cpit_pkg.sv
// Package for the collider pair intersection test.
// Holds the pair kind codes, stream widths, pipeline payload types and a
// signed multiply helper. No dependencies.
package cpit_pkg;

    localparam int IN_TDATA_W  = 352;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    // Fraction bits of the clamped axis coordinate.
    localparam int T_BITS = 30;
    localparam int T_W    = T_BITS + 1;

    typedef enum logic [1:0] {
        KIND_RECT_RECT     = 2'd0,
        KIND_CIRCLE_CIRCLE = 2'd1,
        KIND_RECT_CIRCLE   = 2'd2,
        KIND_CIRCLE_RECT   = 2'd3
    } pair_kind_t;

    typedef struct packed {
        logic [63:0]       rem;
        logic [63:0]       den;
        logic [T_BITS-1:0] quo;
        logic              neg;
        logic              zero;
        logic              sat;
    } axis_div_t;

    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic [61:0]        r2;
        pair_kind_t         kind;
        logic               pre_hit;
    } carry_t;

    function automatic logic signed [63:0] smul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return p[63:0];
    endfunction

endpackage

>>> sv/collider_pair_intersection_test.sv
// Pipelined overlap test for one pair of 2D colliders per item.
// Depends on cpit_pkg for kind codes, payload types and the multiply helper.
//
// Usage: an item enters on the s_axis channel when s_axis_tvalid and
// s_axis_tready are both high. The pair kind travels in s_axis_tuser and
// the offset, the edge vectors and the radius term in s_axis_tdata. One
// result item leaves on the m_axis channel for every accepted item, in order,
// with the overlap flag in bit 0 of m_axis_tdata.
// One item can be accepted every cycle while s_axis_tready is high. The
// pipeline holds the 30 stages of the restoring divider that forms the
// clamped axis coordinates, followed by the split 64-bit squaring stages of
// the closest point distance.
// Reset empties the pipeline and the output; the block takes items in the
// first cycle after reset. When the receiver stalls, the output register
// holds its item and a skid register takes one more; once that is full,
// s_axis_tready drops and the whole pipeline holds without losing anything.
module collider_pair_intersection_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // offset_x, offset_y, first_u_x, first_u_y, first_v_x, first_v_y,
    // second_u_x, second_u_y, second_v_x, second_v_y, radius_term, zero pad
    input  logic [cpit_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // pair_kind
    input  logic [cpit_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // overlapping, zero pad
    output logic [cpit_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int TB   = cpit_pkg::T_BITS;
    localparam int POST = 7;

    logic en;

    // Input unpacking.
    cpit_pkg::pair_kind_t in_kind;
    logic signed [31:0]   in_ox;
    logic signed [31:0]   in_oy;
    logic signed [31:0]   ax [4];
    logic signed [31:0]   ay [4];
    logic [30:0]          in_r;

    always_comb
    begin
        in_kind = cpit_pkg::pair_kind_t'(s_axis_tuser);
        in_ox   = $signed(s_axis_tdata[31:0]);
        in_oy   = $signed(s_axis_tdata[63:32]);
        for (int i = 0; i < 4; i++)
        begin
            ax[i] = $signed(s_axis_tdata[64 + 64*i +: 32]);
            ay[i] = $signed(s_axis_tdata[96 + 64*i +: 32]);
        end
        in_r = s_axis_tdata[350:320];
    end

    // Stage 1: all products.
    logic signed [63:0] rr_pc_reg [4][2];
    logic signed [63:0] rr_pp_reg [4][4][2];
    logic signed [63:0] cc_x2_reg;
    logic signed [63:0] cc_y2_reg;
    logic signed [63:0] rc_pc_reg [2][2];
    logic signed [63:0] rc_pd_reg [2][2];
    cpit_pkg::carry_t   c1_reg;
    logic               v1_reg;

    cpit_pkg::carry_t   c1_next;

    always_comb
    begin
        c1_next.kind    = in_kind;
        c1_next.pre_hit = 1'b0;
        c1_next.r2      = in_r * in_r;
        if (in_kind == cpit_pkg::KIND_CIRCLE_RECT)
        begin
            c1_next.ux = ax[2];
            c1_next.uy = ay[2];
            c1_next.vx = ax[3];
            c1_next.vy = ay[3];
            c1_next.cx = -{in_ox[31], in_ox};
            c1_next.cy = -{in_oy[31], in_oy};
        end
        else
        begin
            c1_next.ux = ax[0];
            c1_next.uy = ay[0];
            c1_next.vx = ax[1];
            c1_next.vy = ay[1];
            c1_next.cx = {in_ox[31], in_ox};
            c1_next.cy = {in_oy[31], in_oy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rr_pc_reg[i][0] <= cpit_pkg::smul({ax[i][31], ax[i]}, {in_ox[31], in_ox});
                rr_pc_reg[i][1] <= cpit_pkg::smul({ay[i][31], ay[i]}, {in_oy[31], in_oy});
                for (int j = 0; j < 4; j++)
                begin
                    rr_pp_reg[i][j][0] <= cpit_pkg::smul({ax[i][31], ax[i]},
                                                         {ax[j][31], ax[j]});
                    rr_pp_reg[i][j][1] <= cpit_pkg::smul({ay[i][31], ay[i]},
                                                         {ay[j][31], ay[j]});
                end
            end
            cc_x2_reg <= cpit_pkg::smul({in_ox[31], in_ox}, {in_ox[31], in_ox});
            cc_y2_reg <= cpit_pkg::smul({in_oy[31], in_oy}, {in_oy[31], in_oy});
            rc_pc_reg[0][0] <= cpit_pkg::smul({c1_next.ux[31], c1_next.ux}, c1_next.cx);
            rc_pc_reg[0][1] <= cpit_pkg::smul({c1_next.uy[31], c1_next.uy}, c1_next.cy);
            rc_pc_reg[1][0] <= cpit_pkg::smul({c1_next.vx[31], c1_next.vx}, c1_next.cx);
            rc_pc_reg[1][1] <= cpit_pkg::smul({c1_next.vy[31], c1_next.vy}, c1_next.cy);
            rc_pd_reg[0][0] <= cpit_pkg::smul({c1_next.ux[31], c1_next.ux},
                                              {c1_next.ux[31], c1_next.ux});
            rc_pd_reg[0][1] <= cpit_pkg::smul({c1_next.uy[31], c1_next.uy},
                                              {c1_next.uy[31], c1_next.uy});
            rc_pd_reg[1][0] <= cpit_pkg::smul({c1_next.vx[31], c1_next.vx},
                                              {c1_next.vx[31], c1_next.vx});
            rc_pd_reg[1][1] <= cpit_pkg::smul({c1_next.vy[31], c1_next.vy},
                                              {c1_next.vy[31], c1_next.vy});
            c1_reg <= c1_next;
        end
    end

    // Stage 2: dot product sums and magnitudes.
    function automatic logic [64:0] dot_sum(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s;
    endfunction

    function automatic logic [63:0] mag65(input logic [64:0] s);
        logic [64:0] m;
        m = s[64] ? (~s + 65'd1) : s;
        return m[63:0];
    endfunction

    logic [63:0]      rr_m_reg [4][4];
    logic [63:0]      rr_cm_reg [4];
    logic [63:0]      cc_sum_reg;
    logic [63:0]      rc_m_reg [2];
    logic             rc_neg_reg [2];
    logic [63:0]      rc_d_reg [2];
    cpit_pkg::carry_t c2_reg;
    logic             v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rr_cm_reg[i] <= mag65(dot_sum(rr_pc_reg[i][0], rr_pc_reg[i][1]));
                for (int j = 0; j < 4; j++)
                begin
                    rr_m_reg[i][j] <= mag65(dot_sum(rr_pp_reg[i][j][0], rr_pp_reg[i][j][1]));
                end
            end
            cc_sum_reg <= {1'b0, cc_x2_reg[62:0]} + {1'b0, cc_y2_reg[62:0]};
            for (int a = 0; a < 2; a++)
            begin
                rc_m_reg[a]   <= mag65(dot_sum(rc_pc_reg[a][0], rc_pc_reg[a][1]));
                rc_neg_reg[a] <= dot_sum(rc_pc_reg[a][0], rc_pc_reg[a][1]) >> 64 != 65'd0;
                rc_d_reg[a]   <= {1'b0, rc_pd_reg[a][0][62:0]} + {1'b0, rc_pd_reg[a][1][62:0]};
            end
            c2_reg <= c1_reg;
        end
    end

    // Stage 3: axis sums, circle compare, divider setup.
    logic [65:0]         rr_acc_reg [4];
    logic [64:0]         rr_cd2_reg [4];
    logic                cc_hit_reg;
    cpit_pkg::axis_div_t div3_reg [2];
    cpit_pkg::carry_t    c3_reg;
    logic                v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rr_acc_reg[i] <= 66'(rr_m_reg[i][0]) + 66'(rr_m_reg[i][1])
                               + 66'(rr_m_reg[i][2]) + 66'(rr_m_reg[i][3]);
                rr_cd2_reg[i] <= {rr_cm_reg[i], 1'b0};
            end
            cc_hit_reg <= cc_sum_reg <= 64'(c2_reg.r2);
            for (int a = 0; a < 2; a++)
            begin
                div3_reg[a].rem  <= rc_m_reg[a];
                div3_reg[a].den  <= rc_d_reg[a];
                div3_reg[a].quo  <= '0;
                div3_reg[a].neg  <= rc_neg_reg[a];
                div3_reg[a].zero <= rc_d_reg[a] == 64'd0;
                div3_reg[a].sat  <= {rc_m_reg[a], 1'b0} >= {1'b0, rc_d_reg[a]};
            end
            c3_reg <= c2_reg;
        end
    end

    // Divider: one quotient bit per stage.
    function automatic cpit_pkg::axis_div_t div_step(input cpit_pkg::axis_div_t a);
        cpit_pkg::axis_div_t o;
        logic [64:0]         r2;
        o     = a;
        r2    = {a.rem, 1'b0};
        o.quo = {a.quo[TB-2:0], 1'b0};
        if (r2 >= {1'b0, a.den})
        begin
            r2       = r2 - {1'b0, a.den};
            o.quo[0] = 1'b1;
        end
        o.rem = r2[63:0];
        return o;
    endfunction

    cpit_pkg::axis_div_t div_reg [TB][2];
    cpit_pkg::carry_t    dc_reg [TB];
    logic                dv_reg [TB];
    cpit_pkg::carry_t    dc0_next;

    always_comb
    begin
        dc0_next = c3_reg;
        if (c3_reg.kind == cpit_pkg::KIND_RECT_RECT)
        begin
            dc0_next.pre_hit = (rr_acc_reg[0] >= 66'(rr_cd2_reg[0]))
                             & (rr_acc_reg[1] >= 66'(rr_cd2_reg[1]))
                             & (rr_acc_reg[2] >= 66'(rr_cd2_reg[2]))
                             & (rr_acc_reg[3] >= 66'(rr_cd2_reg[3]));
        end
        else
        begin
            dc0_next.pre_hit = cc_hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0][0] <= div_step(div3_reg[0]);
            div_reg[0][1] <= div_step(div3_reg[1]);
            dc_reg[0]     <= dc0_next;
            for (int k = 1; k < TB; k++)
            begin
                div_reg[k][0] <= div_step(div_reg[k-1][0]);
                div_reg[k][1] <= div_step(div_reg[k-1][1]);
                dc_reg[k]     <= dc_reg[k-1];
            end
        end
    end

    // Back end: coordinate, closest point, squared distance, compare.
    logic signed [cpit_pkg::T_W-1:0] t_reg [2];
    logic signed [63:0]              pr_reg [4];
    logic signed [63:0]              dxy_reg [2];
    logic [62:0]                     mag_reg [2];
    logic [61:0]                     hh_reg [2];
    logic [62:0]                     hl_reg [2];
    logic [63:0]                     ll_reg [2];
    logic [127:0]                    sq_reg [2];
    logic [127:0]                    dd_reg;
    logic [127:0]                    rs_reg;
    cpit_pkg::carry_t                pc_reg [POST];
    logic                            pv_reg [POST];

    logic signed [cpit_pkg::T_W-1:0] t_next [2];
    logic signed [63:0]              cxs;
    logic signed [63:0]              cys;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            logic [TB-1:0] tm;
            tm = div_reg[TB-1][a].quo;
            if (div_reg[TB-1][a].zero)
            begin
                tm = '0;
            end
            else if (div_reg[TB-1][a].sat)
            begin
                tm = TB'(1) << (TB - 1);
            end
            t_next[a] = div_reg[TB-1][a].neg ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
        end
        cxs = $signed({{31{pc_reg[1].cx[32]}}, pc_reg[1].cx}) <<< TB;
        cys = $signed({{31{pc_reg[1].cy[32]}}, pc_reg[1].cy}) <<< TB;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= t_next[0];
            t_reg[1] <= t_next[1];
            pc_reg[0] <= dc_reg[TB-1];
            for (int s = 1; s < POST; s++)
            begin
                pc_reg[s] <= pc_reg[s-1];
            end
            pr_reg[0] <= cpit_pkg::smul(33'(t_reg[0]), {pc_reg[0].ux[31], pc_reg[0].ux});
            pr_reg[1] <= cpit_pkg::smul(33'(t_reg[1]), {pc_reg[0].vx[31], pc_reg[0].vx});
            pr_reg[2] <= cpit_pkg::smul(33'(t_reg[0]), {pc_reg[0].uy[31], pc_reg[0].uy});
            pr_reg[3] <= cpit_pkg::smul(33'(t_reg[1]), {pc_reg[0].vy[31], pc_reg[0].vy});
            dxy_reg[0] <= pr_reg[0] + pr_reg[1] - cxs;
            dxy_reg[1] <= pr_reg[2] + pr_reg[3] - cys;
            for (int a = 0; a < 2; a++)
            begin
                mag_reg[a] <= dxy_reg[a][63] ? 63'(-dxy_reg[a]) : dxy_reg[a][62:0];
                hh_reg[a]  <= mag_reg[a][62:32] * mag_reg[a][62:32];
                hl_reg[a]  <= mag_reg[a][62:32] * mag_reg[a][31:0];
                ll_reg[a]  <= mag_reg[a][31:0] * mag_reg[a][31:0];
                sq_reg[a]  <= 128'({hh_reg[a], 64'd0}) + (128'(hl_reg[a]) << 33)
                            + 128'(ll_reg[a]);
            end
            dd_reg <= sq_reg[0] + sq_reg[1];
            rs_reg <= 128'(pc_reg[5].r2) << (2 * TB);
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < TB; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            for (int s = 0; s < POST; s++)
            begin
                pv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int k = 1; k < TB; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            pv_reg[0] <= dv_reg[TB-1];
            for (int s = 1; s < POST; s++)
            begin
                pv_reg[s] <= pv_reg[s-1];
            end
        end
    end

    // Output register and skid register.
    logic hit;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_data_reg;
    logic out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic skid_data_reg;
    logic skid_data_next;

    assign en = ~skid_valid_reg;

    always_comb
    begin
        if (pc_reg[POST-1].kind == cpit_pkg::KIND_RECT_CIRCLE
            || pc_reg[POST-1].kind == cpit_pkg::KIND_CIRCLE_RECT)
        begin
            hit = dd_reg <= rs_reg;
        end
        else
        begin
            hit = pc_reg[POST-1].pre_hit;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_next = pv_reg[POST-1];
            out_data_next  = hit;
        end
        else if (pv_reg[POST-1])
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(cpit_pkg::OUT_TDATA_W - 1)'(0), out_data_reg};

endmodule
